FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("label");
`define ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("label");
`else
`define ASSERT_IMP(label, clk, rst, a, b)
`define ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

FILE: rtl/aclp_pkg.sv
// ---------------------------------------------------------------------------
// aclp_pkg
// shared types and constants of the command line parser
// ---------------------------------------------------------------------------
package aclp_pkg;
  localparam logic [2:0] CMD_TARGET = 3'd0;
  localparam logic [2:0] CMD_SAF    = 3'd1;
  localparam logic [2:0] CMD_SAFH   = 3'd2;
  localparam logic [2:0] CMD_HIGH   = 3'd3;
  localparam logic [2:0] CMD_START  = 3'd4;
  localparam logic [2:0] CMD_ABORT  = 3'd5;
  localparam int unsigned VAL_MAX   = 100000;

  // controller to datapath
  typedef struct packed {
    logic store_wr;  // append incoming char
    logic line_rst;  // restart fill index
    logic scan_start; // reset scan pointer and parse state
    logic scan_step;  // consume one char
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic full;      // store holds LINE_LEN-1 chars
    logic rd_valid;  // registered read data available
    logic done;      // parse finished
  } sts_t;
endpackage

FILE: rtl/aclp_ctrl.sv
// ---------------------------------------------------------------------------
// aclp_ctrl
// sequencer: accepts chars, launches and runs the line scan
// ---------------------------------------------------------------------------
module aclp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     in_char,
  output logic           in_stall,
  input  aclp_pkg::sts_t sts,
  input  logic           out_busy,
  output aclp_pkg::ctl_t ctl
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT} state_t;
  state_t state;
  logic   acc;

  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    ctl = '0;
    if (acc && in_char != 8'h0d) begin
      if (in_char == 8'h0a) begin
        ctl.line_rst   = 1'b1;
        ctl.scan_start = 1'b1;
      end else if (sts.full) begin
        ctl.line_rst = 1'b1;
      end else begin
        ctl.store_wr = 1'b1;
      end
    end
    // steps pause while the output register still holds an untaken result
    if (state == S_SCAN && sts.rd_valid && !sts.done && !out_busy) ctl.scan_step = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (ctl.scan_start) state <= S_WAIT;
        S_WAIT: state <= S_SCAN;
        S_SCAN: if (sts.done) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/aclp_dp.sv
// ---------------------------------------------------------------------------
// aclp_dp
// line store, scan pointer and character-serial parse datapath
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module aclp_dp #(
  parameter int LINE_LEN = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_char,
  input  aclp_pkg::ctl_t      ctl,
  output aclp_pkg::sts_t      sts,
  output logic                res_valid,
  output logic [2:0]          res_cmd,
  output logic signed [17:0]  res_val,
  output logic                res_flag
);
  localparam int AW = $clog2(LINE_LEN);
  localparam int CW = $clog2(LINE_LEN + 1);

  // parse phases
  typedef enum logic [3:0] {
    P_LEAD, P_WORD, P_WEND, P_A1, P_WS, P_INT, P_FRAC, P_END
  } ph_t;
  typedef enum logic [1:0] {K_VAL, K_INT, K_WORD} kind_t;

  logic [7:0]    mem [LINE_LEN];
  logic [CW-1:0] fill;
  logic [CW-1:0] len;
  logic [CW-1:0] ptr;
  logic [CW-1:0] ptr_next;
  logic [7:0]    rd;
  logic          rdv;
  ph_t           ph;
  logic [4:0]    cand;  // SAF, SAFH, HIGH, START, ABORT candidates
  logic [2:0]    widx;
  logic [2:0]    cmd;
  kind_t         kind;
  logic          neg, any, nz, ok, dn;
  logic [9:0]    ip;
  logic [6:0]    fr;
  logic [1:0]    nf;
  logic [7:0]    c, u;
  logic [4:0]    cand_next;

  assign sts.full     = (fill == CW'(LINE_LEN - 1));
  assign sts.rd_valid = rdv;
  assign sts.done     = dn;

  // effective char: zero past the line end
  assign c = (ptr > len) ? 8'h00 : ((ptr == len) ? 8'h00 : rd);
  assign u = (c >= "a" && c <= "z") ? c - 8'd32 : c;

  function automatic logic [7:0] wch(input logic [2:0] k, input logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      3'd1: r = (i == 0) ? "S" : (i == 1) ? "A" : (i == 2) ? "F" : ",";
      3'd2: r = (i == 0) ? "S" : (i == 1) ? "A" : (i == 2) ? "F" : (i == 3) ? "H" : ",";
      3'd3: r = (i == 0) ? "H" : (i == 1) ? "I" : (i == 2) ? "G" : (i == 3) ? "H" : ",";
      3'd4: r = (i == 0) ? "S" : (i == 1) ? "T" : (i == 2) ? "A" : (i == 3) ? "R" : "T";
      3'd5: r = (i == 0) ? "A" : (i == 1) ? "B" : (i == 2) ? "O" : (i == 3) ? "R" : "T";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // pointer advances per step; holds at a zero char and when the first
  // number char must be seen again by the integer phase
  always_comb begin
    ptr_next = ptr;
    if (ctl.scan_start) begin
      ptr_next = '0;
    end else if (ctl.scan_step) begin
      if (c != 8'h00 && ptr != CW'(LINE_LEN) &&
          !(ph == P_WS && !(c == " " || (c >= 8'd9 && c <= 8'd13)) &&
            !(c == "+" || c == "-")))
        ptr_next = ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.store_wr) mem[fill[AW-1:0]] <= in_char;
    rd <= mem[ptr_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.line_rst) begin
      fill <= '0;
    end else if (ctl.store_wr) begin
      fill <= fill + 1'b1;
    end
  end

  logic [9:0] ip_mul;
  logic [10:0] ip_sum;
  logic [16:0] h;
  assign ip_sum = 11'(ip) * 11'd10 + 11'(c - "0");
  assign ip_mul = (ip >= 10'd101 || ip_sum > 11'd1001) ? 10'd1001 : ip_sum[9:0];
  assign h = 17'(ip) * 17'd100 + 17'(fr);

  always_comb begin
    cand_next = cand;
    for (int k = 1; k <= 5; k++) begin
      if (cand[k-1] && (widx > ((k == 1) ? 3'd3 : 3'd4) || u != wch(3'(k), widx)))
        cand_next[k-1] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rdv       <= 1'b0;
      dn        <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      ptr       <= ptr_next;
      if (ctl.scan_start) begin
        len  <= fill;
        rdv  <= 1'b0;
        dn   <= 1'b0;
        ph   <= P_LEAD;
        ok   <= 1'b0;
        neg  <= 1'b0; any <= 1'b0; nz <= 1'b0;
        ip   <= '0; fr <= '0; nf <= '0;
        widx <= '0;
        cand <= 5'b11111;
      end else if (!dn && !rdv) begin
        rdv <= 1'b1;
      end else if (ctl.scan_step) begin
        unique case (ph)
          P_LEAD: begin
            if (!(c == " " || c == 8'h09)) begin
              if (u == "T") begin
                ph <= P_A1; cmd <= aclp_pkg::CMD_TARGET; kind <= K_VAL;
              end else if (u == "A") begin
                ph <= P_A1; cmd <= aclp_pkg::CMD_ABORT; kind <= K_WORD;
                cand <= 5'b10000; widx <= 3'd1;
              end else if (u == "S" || u == "H") begin
                ph <= P_WORD; cand <= cand_next; widx <= 3'd1;
              end else begin
                dn <= 1'b1;
              end
            end
          end
          P_A1: begin
            if (cmd == aclp_pkg::CMD_TARGET) begin
              if (c == ",") ph <= P_WS; else dn <= 1'b1;
            end else if (c == 8'h00 || c == 8'h0d) begin
              ok <= 1'b1; ph <= P_END;
            end else if (u == "B") begin
              ph <= P_WORD; widx <= 3'd2;
            end else begin
              dn <= 1'b1;
            end
          end
          P_WORD: begin
            widx <= widx + 1'b1;
            cand <= cand_next;
            if (cand_next == '0) begin
              dn <= 1'b1;
            end else if (cand_next[1] && widx == 3'd4) begin
              cmd <= aclp_pkg::CMD_SAFH; kind <= K_VAL; ph <= P_WS;
            end else if (cand_next[0] && widx == 3'd3) begin
              cmd <= aclp_pkg::CMD_SAF; kind <= K_VAL; ph <= P_WS;
            end else if (cand_next[2] && widx == 3'd4) begin
              cmd <= aclp_pkg::CMD_HIGH; kind <= K_INT; ph <= P_WS;
            end else if (cand_next[3] && widx == 3'd4) begin
              cmd <= aclp_pkg::CMD_START; ph <= P_WEND;
            end else if (cand_next[4] && widx == 3'd4) begin
              cmd <= aclp_pkg::CMD_ABORT; ph <= P_WEND;
            end
          end
          P_WEND: begin
            if (c == 8'h00 || c == 8'h0d || c == " " || c == 8'h09) begin
              ok <= 1'b1; ph <= P_END;
            end else begin
              dn <= 1'b1;
            end
          end
          P_WS: begin
            // a char that is neither blank nor a sign is left in place for the integer phase
            if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
              ph <= P_INT;
              if (c == "+" || c == "-") neg <= (c == "-");
            end
          end
          P_INT: begin
            if (c >= "0" && c <= "9") begin
              ip <= ip_mul; any <= 1'b1;
              if (c != "0") nz <= 1'b1;
            end else if (c == "." && kind == K_VAL) begin
              ph <= P_FRAC;
            end else begin
              ok <= any; ph <= P_END;
            end
          end
          P_FRAC: begin
            if (c >= "0" && c <= "9") begin
              any <= 1'b1;
              if (nf == 2'd0) fr <= 7'(c - "0") * 7'd10;
              else if (nf == 2'd1) fr <= fr + 7'(c - "0");
              if (nf < 2'd2) nf <= nf + 1'b1;
            end else begin
              ok <= any; ph <= P_END;
            end
          end
          P_END: begin
            dn <= 1'b1;
            if (ok) begin
              res_valid <= 1'b1;
              res_cmd   <= cmd;
              res_flag  <= (cmd == aclp_pkg::CMD_HIGH) ? nz : 1'b0;
              if (cmd <= aclp_pkg::CMD_SAFH) begin
                res_val <= neg
                  ? -$signed(18'((h > 17'(aclp_pkg::VAL_MAX)) ? 17'(aclp_pkg::VAL_MAX) : h))
                  :  $signed(18'((h > 17'(aclp_pkg::VAL_MAX)) ? 17'(aclp_pkg::VAL_MAX) : h));
              end else begin
                res_val <= '0;
              end
            end
          end
          default: dn <= 1'b1;
        endcase
      end
    end
  end

  `ASSERT_NXT(a_res_ends_scan, clk, rst, res_valid, dn)
  `ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= CW'(LINE_LEN - 1))
  `ASSERT_IMP(a_no_wr_scan, clk, rst, !dn, !ctl.store_wr)
endmodule

FILE: rtl/ascii_command_line_parser.sv
// ---------------------------------------------------------------------------
// ascii_command_line_parser
// serial command line parser: collects chars, parses a line at newline
// ---------------------------------------------------------------------------
//  channel | signals                                          | direction
//  input   | in_valid, in_stall, rx_char                      | in
//  output  | out_valid, out_stall, command, value_hundredths, | out
//          | flag_on                                          |
//
// ordinary chars are stored without a stall; carriage returns are dropped
// a newline holds input while the scan walks the line store
// through its registered read port
// reset clears fill index and the sequencer; store contents need none
// scan steps pause while an older result still waits downstream
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module ascii_command_line_parser #(
  parameter int LINE_LEN = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         command,
  output logic signed [17:0] value_hundredths,
  output logic               flag_on
);
  aclp_pkg::ctl_t    ctl;
  aclp_pkg::sts_t    sts;
  logic              res_valid;
  logic [2:0]        res_cmd;
  logic signed [17:0] res_val;
  logic              res_flag;
  logic              out_busy;

  // pause the scan while an older result still waits
  assign out_busy = out_valid && out_stall;

  aclp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_char  (rx_char),
    .in_stall (in_stall),
    .sts      (sts),
    .out_busy (out_busy),
    .ctl      (ctl)
  );

  aclp_dp #(.LINE_LEN(LINE_LEN)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_char   (rx_char),
    .ctl       (ctl),
    .sts       (sts),
    .res_valid (res_valid),
    .res_cmd   (res_cmd),
    .res_val   (res_val),
    .res_flag  (res_flag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid        <= 1'b1;
      command          <= res_cmd;
      value_hundredths <= res_val;
      flag_on          <= res_flag;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_IMP(a_cmd_range, clk, rst, out_valid, command <= aclp_pkg::CMD_ABORT)
  `ASSERT_IMP(a_flag_high, clk, rst, out_valid && flag_on, command == aclp_pkg::CMD_HIGH)
  `ASSERT_IMP(a_no_overrun, clk, rst, res_valid, !out_busy)
endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// checks the command line parser against an in-bench line model: directed
// lines, random well-formed, broken and noise lines under idle and stall mixes
// ---------------------------------------------------------------------------
module tb;
  localparam int STORE_LEN = 128;
  localparam int WD_LIMIT  = 5000;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [17:0] val;
    logic               flag;
  } cmd_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_char = 8'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         command;
  logic signed [17:0] value_hundredths;
  logic               flag_on;

  // pending parsed commands, oldest first
  cmd_result_t pending_cmds[$];

  // line model state
  byte unsigned line_buf[STORE_LEN];
  byte unsigned scan_buf[STORE_LEN + 1];
  int           fill_cnt = 0;

  byte unsigned line_q[$];
  int           send_pct_idle  = 0;
  int           recv_pct_stall = 0;
  int           hold_req       = 0;
  int           mismatches     = 0;
  int           idle_cycles    = 0;
  int           chars_sent     = 0;

  ascii_command_line_parser DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_char(rx_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .command(command), .value_hundredths(value_hundredths), .flag_on(flag_on)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------ line model
  function automatic byte unsigned sc(int i);
    return (i < STORE_LEN + 1) ? scan_buf[i] : 8'd0;
  endfunction

  function automatic byte unsigned upc(byte unsigned c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic bit is_ws(byte unsigned c);
    return c == " " || (c >= 9 && c <= 13);
  endfunction

  function automatic bit is_dig(byte unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_end(byte unsigned c);
    return c == 0 || c == 13 || c == " " || c == 9;
  endfunction

  function automatic bit word_at(int p, string w);
    for (int i = 0; i < w.len(); i++)
      if (upc(sc(p + i)) != w[i]) return 1'b0;
    return 1'b1;
  endfunction

  // decimal value in hundredths, extra fraction digits truncated
  function automatic bit scan_value(int p, output int v);
    bit          neg = 0, any = 0;
    int unsigned ip = 0, fr = 0, nf = 0, h;
    v = 0;
    while (is_ws(sc(p))) p++;
    if (sc(p) == "+" || sc(p) == "-") begin
      neg = sc(p) == "-";
      p++;
    end
    while (is_dig(sc(p))) begin
      ip = ip * 10 + (sc(p) - "0");
      if (ip > 1001) ip = 1001;
      any = 1;
      p++;
    end
    if (sc(p) == ".") begin
      p++;
      while (is_dig(sc(p))) begin
        if (nf == 0) fr += 10 * (sc(p) - "0");
        else if (nf == 1) fr += sc(p) - "0";
        if (nf < 2) nf++;
        any = 1;
        p++;
      end
    end
    if (!any) return 1'b0;
    h = ip * 100 + fr;
    if (h > aclp_pkg::VAL_MAX) h = aclp_pkg::VAL_MAX;
    v = neg ? -int'(h) : int'(h);
    return 1'b1;
  endfunction

  function automatic bit scan_int_nz(int p, output bit nz);
    bit any = 0;
    nz = 0;
    while (is_ws(sc(p))) p++;
    if (sc(p) == "+" || sc(p) == "-") p++;
    while (is_dig(sc(p))) begin
      if (sc(p) != "0") nz = 1;
      any = 1;
      p++;
    end
    return any;
  endfunction

  function automatic bit parse_cmd_line(output cmd_result_t r);
    int p = 0;
    int v = 0;
    bit f = 0;
    r = '0;
    while (sc(p) == " " || sc(p) == 9) p++;
    if (upc(sc(p)) == "T") begin
      if (sc(p + 1) != "," || !scan_value(p + 2, v)) return 1'b0;
      r.cmd = aclp_pkg::CMD_TARGET;
    end else if (word_at(p, "SAF,")) begin
      if (!scan_value(p + 4, v)) return 1'b0;
      r.cmd = aclp_pkg::CMD_SAF;
    end else if (word_at(p, "SAFH,")) begin
      if (!scan_value(p + 5, v)) return 1'b0;
      r.cmd = aclp_pkg::CMD_SAFH;
    end else if (word_at(p, "HIGH,")) begin
      if (!scan_int_nz(p + 5, f)) return 1'b0;
      r.cmd = aclp_pkg::CMD_HIGH;
    end else if (word_at(p, "START") && word_end(sc(p + 5))) begin
      r.cmd = aclp_pkg::CMD_START;
    end else if ((upc(sc(p)) == "A" && (sc(p + 1) == 0 || sc(p + 1) == 13)) ||
                 (word_at(p, "ABORT") && word_end(sc(p + 5)))) begin
      r.cmd = aclp_pkg::CMD_ABORT;
    end else begin
      return 1'b0;
    end
    r.val  = v[17:0];
    r.flag = f;
    return 1'b1;
  endfunction

  // model update for one accepted char
  task automatic line_model_char(byte unsigned c);
    cmd_result_t r;
    int          len;
    if (c == 13) return;
    if (c == 10) begin
      len = (fill_cnt > STORE_LEN - 1) ? STORE_LEN - 1 : fill_cnt;
      foreach (scan_buf[i]) scan_buf[i] = (i < len) ? line_buf[i] : 8'd0;
      fill_cnt = 0;
      if (parse_cmd_line(r)) pending_cmds.push_back(r);
    end else if (fill_cnt < STORE_LEN - 1) begin
      line_buf[fill_cnt] = c;
      fill_cnt++;
    end else begin
      fill_cnt = 0;   // overflow: char dropped, line restarts
    end
  endtask

  // ------------------------------------------------------------ sender
  task automatic send_char(byte unsigned c);
    while ($urandom_range(99) < send_pct_idle) begin
      in_valid <= 1'b0;
      rx_char  <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_char  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    line_model_char(c);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
  endtask

  // random letter case
  function automatic byte unsigned mix_case(byte unsigned c);
    if (c >= "A" && c <= "Z" && $urandom_range(1)) return c + 8'd32;
    return c;
  endfunction

  task automatic push_word(string w);
    for (int i = 0; i < w.len(); i++) line_q.push_back(mix_case(w[i]));
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_number(bit int_only);
    byte unsigned ws_set[4] = '{8'd32, 8'd9, 8'd11, 8'd12};
    int n;
    if ($urandom_range(3) == 0) line_q.push_back(ws_set[$urandom_range(3)]);
    case ($urandom_range(2))
      0: line_q.push_back("-");
      1: line_q.push_back("+");
      default: ;
    endcase
    n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 7);
    repeat (n) line_q.push_back(8'("0" + $urandom_range(9)));
    if (!int_only && $urandom_range(1)) begin
      line_q.push_back(".");
      repeat ($urandom_range(4)) line_q.push_back(8'("0" + $urandom_range(9)));
    end
    if ($urandom_range(4) == 0) push_str(" x1e5");
  endtask

  task automatic build_random_line();
    int r = $urandom_range(99);
    line_q.delete();
    if (r < 90) begin
      repeat ($urandom_range(2)) line_q.push_back($urandom_range(1) ? 8'd32 : 8'd9);
      case ($urandom_range(5))
        0: begin push_word("T,"); push_number(0); end
        1: begin push_word("SAF,"); push_number(0); end
        2: begin push_word("SAFH,"); push_number(0); end
        3: begin push_word("HIGH,"); push_number(1); end
        4: begin
          push_word("START");
          case ($urandom_range(3))
            0: push_str(" now");
            1: line_q.push_back(8'd9);
            2: push_str("X");
            default: ;
          endcase
        end
        default: begin
          if ($urandom_range(1)) push_word("A");
          else push_word("ABORT");
          if ($urandom_range(3) == 0) push_str(" !");
        end
      endcase
      if ($urandom_range(4) == 0) line_q.push_back(8'd13);
      // broken variant: one char replaced
      if (r >= 75) line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom);
    end else begin
      repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom));
    end
    line_q.push_back(8'd10);
  endtask

  // ------------------------------------------------------------ receiver
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct_stall);
    end
  end

  // result check against oldest pending command
  always @(posedge clk) begin
    cmd_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: cmd %0d val %0d flag %0d",
                   command, value_hundredths, flag_on);
      end else begin
        want = pending_cmds.pop_front();
        if (want.cmd !== command || want.val !== value_hundredths ||
            want.flag !== flag_on) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cmd %0d val %0d flag %0d, got cmd %0d val %0d flag %0d",
                     want.cmd, want.val, want.flag, command, value_hundredths, flag_on);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------ tests
  task automatic test_directed();
    string lines[$] = '{
      "T,12.345", "t,-99999", "SAF,+0.5", "safh, \t7.", "SAFH,.09",
      "HIGH,0000", "high,-0012", "HIGH,x", "START", "start now", "STARTX",
      "A", "a\r", "ABORT", "abort\tgo", "AB", "T", "T,", "Tx,1", "SAF,abc",
      "  \tSTART", "", "hello", "T,1e5", "T,5000000.999"};
    foreach (lines[i]) begin
      line_q.delete();
      push_str(lines[i]);
      line_q.push_back(8'd10);
      send_line();
    end
    // zero byte ends the line early
    line_q = '{"S", "A", "F", ",", "3", 8'd0, "9", 8'd10};
    send_line();
    // longest line that fits the store
    line_q.delete();
    push_str("HIGH,1");
    repeat (STORE_LEN - 1 - 6) line_q.push_back(" ");
    line_q.push_back(8'd10);
    send_line();
    // overflow: one char too many, then a fresh command
    line_q.delete();
    repeat (STORE_LEN) line_q.push_back("x");
    push_str("ABORT");
    line_q.push_back(8'd10);
    send_line();
    // all-ones byte and all bit positions
    line_q = '{8'hff, 8'h80, 8'h7f, 8'd10};
    send_line();
  endtask

  task automatic test_random(int pct_idle, int pct_stall, int n_chars);
    int stop_at = chars_sent + n_chars;
    send_pct_idle  = pct_idle;
    recv_pct_stall = pct_stall;
    while (chars_sent < stop_at) begin
      build_random_line();
      send_line();
    end
  endtask

  // long receiver hold while input keeps coming
  task automatic test_backpressure();
    send_pct_idle  = 0;
    recv_pct_stall = 0;
    hold_req       = 400;
    repeat (12) begin
      line_q.delete();
      push_word("SAF,");
      push_number(0);
      line_q.push_back(8'd10);
      send_line();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 300);
    test_random(62, 0, 300);
    test_random(0, 62, 300);
    test_random(23, 23, 250);
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
